>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bfl_pkg.sv
`default_nettype none

package bfl_pkg;

  // Default values of the top-level parameters.
  localparam int GLYPH_ENTRIES_DEF = 256;
  localparam int POS_BITS_DEF      = 16;
  localparam int SCALE_FRAC_DEF    = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_COLOR = 1'b1;
  localparam logic [15:0] SCALE_RESET = 16'd256;
  localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

  // Request types.
  localparam logic [1:0] REQ_GLYPH = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_CHAR  = 2'd2;

  // Control characters.
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // Tab stops every this many scaled maximum widths.
  localparam logic [2:0] TAB_STOPS = 3'd4;

  // Work classes that the front hands to the back.
  typedef enum logic [2:0] {
    KIND_GLYPH,
    KIND_START,
    KIND_NEWLINE,
    KIND_TAB,
    KIND_CHAR
  } kind_e;

  // One glyph table entry, 64 bits.
  typedef struct packed {
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [7:0]         width;
    logic [7:0]         height;
    logic signed [7:0]  off_x;
    logic signed [7:0]  off_y;
    logic [7:0]         advance;
  } glyph_t;

  // One queued work item.
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         code;
    glyph_t             glyph;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } item_t;

  // One blit beat.
  typedef struct packed {
    logic [11:0]        src_left;
    logic [11:0]        src_top;
    logic [12:0]        src_right;
    logic [12:0]        src_bottom;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [31:0]        color;
  } blit_t;

endpackage

`default_nettype wire

>>> design/bfl_ram.sv
`default_nettype none

module bfl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/bfl_fifo.sv
`default_nettype none

module bfl_fifo import bfl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> design/bfl_front.sv
`default_nettype none

module bfl_front import bfl_pkg::*; #(
  parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF
) (
  input  wire logic              start_i,
  input  wire logic              full_i,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [11:0]       glyph_src_x_i,
  input  wire logic [11:0]       glyph_src_y_i,
  input  wire logic [7:0]        glyph_width_i,
  input  wire logic [7:0]        glyph_height_i,
  input  wire logic signed [7:0] glyph_off_x_i,
  input  wire logic signed [7:0] glyph_off_y_i,
  input  wire logic [7:0]        glyph_advance_i,
  input  wire logic signed [15:0] start_x_i,
  input  wire logic signed [15:0] start_y_i,
  output logic                   busy_o,
  output logic                   push_o,
  output item_t                  item_o
);

  logic  keep;
  kind_e kind;

  // Sort each request into a work class; writes out of range and unused
  // request types are taken and dropped here.
  always_comb begin
    keep = 1'b1;
    kind = KIND_CHAR;
    case (req_type_i)
      REQ_GLYPH: begin
        kind = KIND_GLYPH;
        keep = (9'(char_code_i) < 9'(GLYPH_ENTRIES));
      end
      REQ_START: begin
        kind = KIND_START;
      end
      REQ_CHAR: begin
        if (char_code_i == CH_NEWLINE) begin
          kind = KIND_NEWLINE;
        end else if (char_code_i == CH_TAB) begin
          kind = KIND_TAB;
        end else begin
          kind = KIND_CHAR;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i && keep;

  always_comb begin
    item_o                = '0;
    item_o.kind           = kind;
    item_o.code           = char_code_i;
    item_o.glyph.src_x    = glyph_src_x_i;
    item_o.glyph.src_y    = glyph_src_y_i;
    item_o.glyph.width    = glyph_width_i;
    item_o.glyph.height   = glyph_height_i;
    item_o.glyph.off_x    = glyph_off_x_i;
    item_o.glyph.off_y    = glyph_off_y_i;
    item_o.glyph.advance  = glyph_advance_i;
    item_o.start_x        = start_x_i;
    item_o.start_y        = start_y_i;
  end

endmodule

`default_nettype wire

>>> design/bfl_back.sv
`default_nettype none

module bfl_back import bfl_pkg::*; #(
  parameter int GLYPH_ENTRIES   = GLYPH_ENTRIES_DEF,
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire item_t       head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  input  wire logic [15:0] scale_i,
  input  wire logic [31:0] color_i,
  output logic             res_valid_o,
  output blit_t            res_o
);

  localparam int IDX_W   = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int F       = SCALE_FRAC_BITS;
  localparam int PROD_W  = 26;
  localparam int W_W     = 24;
  localparam int STEP_W  = 27;
  localparam int SW      = ((POS_BITS > STEP_W) ? POS_BITS : STEP_W) + 2;
  localparam int DW      = POS_BITS + 1;
  localparam int NUM_W   = DW + F;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam logic signed [SW-1:0] POS_MAX =
    {{(SW - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [SW-1:0] D16_MAX = {{(SW - 15){1'b0}}, {15{1'b1}}};
  localparam logic signed [SW-1:0] D16_MIN = ~D16_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLYPH_RD,
    ST_TAB_DIV,
    ST_TAB_ADV
  } state_e;

  // Signed value times scale, truncated toward zero.
  function automatic logic signed [PROD_W-1:0] scale_mul(
    input logic signed [8:0] v,
    input logic [15:0]       s
  );
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shf;
    prod = PROD_W'(v) * PROD_W'(signed'({1'b0, s}));
    shf  = prod >>> F;
    if (prod < 0 && prod[F-1:0] != '0) begin
      shf = shf + PROD_W'(1);
    end
    return shf;
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
    return r[POS_BITS-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v > D16_MAX) ? D16_MAX : ((v < D16_MIN) ? D16_MIN : v);
    return r[15:0];
  endfunction

  state_e                     state_q, state_d;
  logic signed [POS_BITS-1:0] cursor_x_q, cursor_x_d;
  logic signed [POS_BITS-1:0] cursor_y_q, cursor_y_d;
  logic signed [POS_BITS-1:0] line_x_q, line_x_d;
  logic [7:0]                 maxw_q, maxw_d;
  logic [7:0]                 maxh_q, maxh_d;
  logic [GLYPH_ENTRIES-1:0]   vld_q, vld_d;
  logic                       hit_q, hit_d;
  logic [W_W-1:0]             w_q, w_d;
  logic [NUM_W-1:0]           num_q, num_d;
  logic [W_W-1:0]             rem_q, rem_d;
  logic [1:0]                 quo_q, quo_d;
  logic                       neg_q, neg_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       res_valid_q, res_valid_d;
  blit_t                      res_q, res_d;

  logic                       ram_we;
  logic                       ram_re;
  logic [IDX_W-1:0]           ram_waddr;
  logic [IDX_W-1:0]           ram_raddr;
  logic [$bits(glyph_t)-1:0]  ram_rdata;

  logic [IDX_W-1:0]           idx;
  logic                       in_range;
  glyph_t                     g;
  logic signed [DW-1:0]       diff;
  logic [DW-1:0]              abs_diff;
  logic [W_W:0]               trial;
  logic [2:0]                 t;
  logic [STEP_W-1:0]          step;

  // Glyph table; entries that were never written read as zero through vld_q.
  bfl_ram #(
    .WIDTH ($bits(glyph_t)),
    .DEPTH (GLYPH_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (head_i.glyph),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx       = head_i.code[IDX_W-1:0];
  assign in_range  = (9'(head_i.code) < 9'(GLYPH_ENTRIES));
  assign ram_waddr = idx;
  assign ram_raddr = idx;

  // Sequencer of the back: one queued item at a time.
  always_comb begin
    state_d     = state_q;
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    line_x_d    = line_x_q;
    maxw_d      = maxw_q;
    maxh_d      = maxh_q;
    vld_d       = vld_q;
    hit_d       = hit_q;
    w_d         = w_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    g           = hit_q ? glyph_t'(ram_rdata) : '0;
    diff        = DW'(cursor_x_q) - DW'(line_x_q);
    abs_diff    = diff[DW-1] ? DW'(-diff) : DW'(diff);
    trial       = {rem_q, num_q[NUM_W-1]};
    t           = neg_q ? (TAB_STOPS + {1'b0, quo_q}) : (TAB_STOPS - {1'b0, quo_q});
    step        = (STEP_W'(t) * STEP_W'(w_q)) >> F;

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            KIND_GLYPH: begin
              ram_we     = 1'b1;
              vld_d[idx] = 1'b1;
              if (head_i.glyph.width > maxw_q) begin
                maxw_d = head_i.glyph.width;
              end
              if (head_i.glyph.height > maxh_q) begin
                maxh_d = head_i.glyph.height;
              end
            end
            KIND_START: begin
              cursor_x_d = sat_pos(SW'(head_i.start_x));
              cursor_y_d = sat_pos(SW'(head_i.start_y));
              line_x_d   = sat_pos(SW'(head_i.start_x));
            end
            KIND_NEWLINE: begin
              cursor_y_d = sat_pos(SW'(cursor_y_q) + SW'(scale_mul({1'b0, maxh_q}, scale_i)));
              cursor_x_d = line_x_q;
            end
            KIND_TAB: begin
              w_d     = W_W'(maxw_q) * W_W'(scale_i);
              num_d   = {abs_diff, {F{1'b0}}};
              neg_d   = diff[DW-1];
              rem_d   = '0;
              quo_d   = '0;
              cnt_d   = '0;
              state_d = ST_TAB_DIV;
            end
            KIND_CHAR: begin
              ram_re  = in_range;
              hit_d   = in_range && vld_q[idx];
              state_d = ST_GLYPH_RD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // Table data is back: form the blit and advance the cursor.
      ST_GLYPH_RD: begin
        res_d.src_left   = g.src_x;
        res_d.src_top    = g.src_y;
        res_d.src_right  = 13'(g.src_x) + 13'(g.width);
        res_d.src_bottom = 13'(g.src_y) + 13'(g.height);
        res_d.dest_x     = sat16(SW'(cursor_x_q) +
                                 SW'(scale_mul({g.off_x[7], g.off_x}, scale_i)));
        res_d.dest_y     = sat16(SW'(cursor_y_q) +
                                 SW'(scale_mul({g.off_y[7], g.off_y}, scale_i)));
        res_d.color      = color_i;
        res_valid_d      = 1'b1;
        cursor_x_d = sat_pos(SW'(cursor_x_q) + SW'(scale_mul({1'b0, g.advance}, scale_i)));
        state_d    = ST_IDLE;
      end

      // Restoring division, one quotient bit a cycle; only the two low
      // quotient bits are kept since the tab step needs the quotient mod 4.
      ST_TAB_DIV: begin
        if (w_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          if (trial >= {1'b0, w_q}) begin
            rem_d = W_W'(trial - {1'b0, w_q});
            quo_d = {quo_q[0], 1'b1};
          end else begin
            rem_d = trial[W_W-1:0];
            quo_d = {quo_q[0], 1'b0};
          end
          num_d = num_q << 1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(NUM_W - 1)) begin
            state_d = ST_TAB_ADV;
          end
        end
      end

      // Move to the next tab stop.
      ST_TAB_ADV: begin
        cursor_x_d = sat_pos(SW'(cursor_x_q) + SW'(signed'({1'b0, step})));
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      line_x_q    <= '0;
      maxw_q      <= '0;
      maxh_q      <= '0;
      vld_q       <= '0;
      hit_q       <= 1'b0;
      w_q         <= '0;
      num_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      line_x_q    <= line_x_d;
      maxw_q      <= maxw_d;
      maxh_q      <= maxh_d;
      vld_q       <= vld_d;
      hit_q       <= hit_d;
      w_q         <= w_d;
      num_q       <= num_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> design/bitmap_font_text_layout_top.sv
// Bitmap font text layout. A request is taken on a clock edge with start high
// and busy low and, unless dropped as out of range or of an unused type, goes
// into a two-deep queue; busy is high only while that queue is full. The back
// takes one queued request at a time: a glyph write, a string start or a
// newline is handled from the idle state, a drawn character as a glyph table
// read, then the blit and the cursor step, and a tab as a bit-serial division
// that finds the current tab stop, then the cursor step to it (both skipped
// when the maximum glyph width or the scale is zero). Each blit is shown on
// the result ports for exactly one cycle with result_valid_o high, and
// blits never abut; the receiver cannot stall it and must take it then.
// The glyph table reads as all zero after reset through per-entry valid
// bits, so no clearing pass is needed. Write scale and draw_color over the
// register port only while the block is idle; a register write never stalls.
`default_nettype none

module bitmap_font_text_layout_top import bfl_pkg::*; #(
  parameter int GLYPH_ENTRIES   = GLYPH_ENTRIES_DEF,
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [7:0]            char_code_i,
  input  wire logic [11:0]           glyph_src_x_i,
  input  wire logic [11:0]           glyph_src_y_i,
  input  wire logic [7:0]            glyph_width_i,
  input  wire logic [7:0]            glyph_height_i,
  input  wire logic signed [7:0]     glyph_off_x_i,
  input  wire logic signed [7:0]     glyph_off_y_i,
  input  wire logic [7:0]            glyph_advance_i,
  input  wire logic signed [15:0]    start_x_i,
  input  wire logic signed [15:0]    start_y_i,
  output logic                       result_valid_o,
  output logic [11:0]                src_left_o,
  output logic [11:0]                src_top_o,
  output logic [12:0]                src_right_o,
  output logic [12:0]                src_bottom_o,
  output logic signed [15:0]         dest_x_o,
  output logic signed [15:0]         dest_y_o,
  output logic [31:0]                blit_color_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [15:0] scale_q;
  logic [31:0] color_q;
  logic        cfg_we;
  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  item_t       push_item;
  item_t       head_item;
  logic        res_valid;
  blit_t       res;

  // Register port: no wait states.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      color_q <= COLOR_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_SCALE: scale_q <= pwdata[15:0];
        REG_COLOR: color_q <= pwdata;
        default:   color_q <= color_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE: prdata = {16'd0, scale_q};
      REG_COLOR: prdata = color_q;
      default:   prdata = '0;
    endcase
  end

  // Front: take and sort requests.
  bfl_front #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES)
  ) u_front (
    .start_i         (start),
    .full_i          (full),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .glyph_src_x_i   (glyph_src_x_i),
    .glyph_src_y_i   (glyph_src_y_i),
    .glyph_width_i   (glyph_width_i),
    .glyph_height_i  (glyph_height_i),
    .glyph_off_x_i   (glyph_off_x_i),
    .glyph_off_y_i   (glyph_off_y_i),
    .glyph_advance_i (glyph_advance_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .busy_o          (busy),
    .push_o          (push),
    .item_o          (push_item)
  );

  // Queue between front and back.
  bfl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty),
    .full_o  (full)
  );

  // Back: glyph table, cursor and blit generation.
  bfl_back #(
    .GLYPH_ENTRIES   (GLYPH_ENTRIES),
    .POS_BITS        (POS_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .scale_i     (scale_q),
    .color_i     (color_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign result_valid_o = res_valid;
  assign src_left_o     = res.src_left;
  assign src_top_o      = res.src_top;
  assign src_right_o    = res.src_right;
  assign src_bottom_o   = res.src_bottom;
  assign dest_x_o       = res.dest_x;
  assign dest_y_o       = res.dest_y;
  assign blit_color_o   = res.color;

endmodule

`default_nettype wire

>>> design/bfl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bfl_checker import bfl_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  result_valid_o,
  input wire logic [11:0]           src_left_o,
  input wire logic [11:0]           src_top_o,
  input wire logic [12:0]           src_right_o,
  input wire logic [12:0]           src_bottom_o,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic                  pready,
  input wire logic [APB_ADDR_W-1:0] paddr,
  input wire logic [31:0]           pwdata,
  input wire logic [31:0]           prdata
);

  logic wr_beat;

  assign wr_beat = psel && penable && pwrite && pready;

  // A drawn character needs a table read before its blit, so strobes never abut.
  `BFL_ASSERT_NEXT(a_strobe_gap, clk_i, rst_ni, result_valid_o, !result_valid_o, "adjacent blit strobes")

  // The source rectangle spans at most one glyph of 255 pixels each way.
  `BFL_ASSERT_NOW(a_src_rect, clk_i, rst_ni, result_valid_o, (src_right_o >= 13'(src_left_o)) && (src_bottom_o >= 13'(src_top_o)) && ((src_right_o - 13'(src_left_o)) <= 13'd255) && ((src_bottom_o - 13'(src_top_o)) <= 13'd255), "source rectangle out of shape")

  // A color write reads back on the next cycle.
  `BFL_ASSERT_NOW(a_color_rb, clk_i, rst_ni, $past(rst_ni) && $past(wr_beat) && $past(paddr[2]) && paddr[2], prdata == $past(pwdata), "color readback mismatch")

  // A scale write reads back on the next cycle, upper half zero.
  `BFL_ASSERT_NOW(a_scale_rb, clk_i, rst_ni, $past(rst_ni) && $past(wr_beat) && !$past(paddr[2]) && !paddr[2], (prdata[15:0] == $past(pwdata[15:0])) && (prdata[31:16] == 16'd0), "scale readback mismatch")

endmodule

bind bitmap_font_text_layout_top bfl_checker u_bfl_checker (.*);

`default_nettype wire
